### design/tlnds_pkg.sv
package tlnds_pkg;

	localparam int MaxBytes = 5;
	localparam int CntW     = 3;

	typedef logic [7:0] byte_t;

	localparam byte_t ChCr  = 8'h0D;
	localparam byte_t ChLf  = 8'h0A;
	localparam byte_t ChDot = 8'h2E;

	typedef struct packed {
		logic pending_return;
		logic line_start;
	} line_state_t;

	localparam line_state_t StateReset = '{pending_return: 1'b0, line_start: 1'b1};

	typedef struct packed {
		byte_t [MaxBytes-1:0] bytes;
		logic  [CntW-1:0]     count;
	} seq_t;

	typedef struct packed {
		logic            free;
		logic [CntW-1:0] count;
	} ser_status_t;

endpackage

### design/tlnds_encode.sv
module tlnds_encode import tlnds_pkg::*; (
	input  byte_t       data_byte,
	input  logic        end_of_file,
	input  line_state_t state,
	output seq_t        seq,
	output line_state_t state_next
);

	logic [CntW-1:0] n;
	logic            pr;
	logic            ls;
	logic            done;

	always_comb begin
		seq  = '0;
		n    = '0;
		pr   = state.pending_return;
		ls   = state.line_start;
		done = 1'b0;
		if (end_of_file) begin
			if (pr) begin
				seq.bytes[n] = ChCr; n = n + 1'b1;
				seq.bytes[n] = ChLf; n = n + 1'b1;
				ls = 1'b1;
			end
			if (!ls) begin
				seq.bytes[n] = ChCr; n = n + 1'b1;
				seq.bytes[n] = ChLf; n = n + 1'b1;
			end
			seq.bytes[n] = ChDot; n = n + 1'b1;
			seq.bytes[n] = ChCr;  n = n + 1'b1;
			seq.bytes[n] = ChLf;  n = n + 1'b1;
			pr = StateReset.pending_return;
			ls = StateReset.line_start;
		end else begin
			if (pr) begin
				pr = 1'b0;
				seq.bytes[n] = ChCr; n = n + 1'b1;
				seq.bytes[n] = ChLf; n = n + 1'b1;
				ls = 1'b1;
				done = (data_byte == ChLf);
			end
			if (!done) begin
				if (data_byte == ChCr) begin
					pr = 1'b1;
				end else if (data_byte == ChLf) begin
					seq.bytes[n] = ChCr; n = n + 1'b1;
					seq.bytes[n] = ChLf; n = n + 1'b1;
					ls = 1'b1;
				end else begin
					if (ls && data_byte == ChDot) begin
						seq.bytes[n] = ChDot; n = n + 1'b1;
					end
					seq.bytes[n] = data_byte; n = n + 1'b1;
					ls = 1'b0;
				end
			end
		end
		seq.count = n;
		state_next.pending_return = pr;
		state_next.line_start     = ls;
	end

endmodule

### design/tlnds_serializer.sv
module tlnds_serializer import tlnds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  seq_t        seq,
	input  logic        result_stall,
	output logic        result_valid,
	output byte_t       out_byte,
	output logic        last,
	output ser_status_t status
);

	byte_t           bytes_q [MaxBytes];
	logic [CntW-1:0] cnt_q;
	logic            take;

	assign result_valid = (cnt_q != '0);
	assign out_byte     = bytes_q[0];
	assign last         = (cnt_q == CntW'(1));
	assign take         = result_valid && !result_stall;
	assign status.free  = (cnt_q == '0) || (last && !result_stall);
	assign status.count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= seq.count;
		end else if (take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MaxBytes; i++) begin
				bytes_q[i] <= seq.bytes[i];
			end
		end else if (take) begin
			for (int i = 0; i < MaxBytes - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
		end
	end

endmodule

### design/text_line_normalizer_dot_stuffer_top.sv
// Text line normalizer with dot stuffing. Every line end (CR, LF or CR LF) leaves
// as CR LF, a dot opening a line is doubled, and an end-of-file item closes an open
// line and appends the terminator dot CR LF, then the block is ready for the next
// file. Each item passes an input register, is encoded into zero to five bytes and
// is loaded into an output shift register that sends one byte per cycle while
// result_stall is low, with last set on the final byte of the item. An item holds
// the output until its bytes are sent (a bare CR gives none); items of at most
// one byte pass one per cycle if not stalled; the byte-wide port sets the rate.
module text_line_normalizer_dot_stuffer_top import tlnds_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  byte_t data_byte,
	input  logic  end_of_file,
	output logic  result_valid,
	input  logic  result_stall,
	output byte_t out_byte,
	output logic  last
);

	logic        valid_s1;
	byte_t       data_byte_s1;
	logic        eof_s1;
	line_state_t state_q;
	line_state_t state_next;
	seq_t        seq;
	ser_status_t ser_status;
	logic        accept;
	logic        move;

	assign move       = valid_s1 && ser_status.free;
	assign item_stall = valid_s1 && !ser_status.free;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= StateReset;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_byte_s1 <= data_byte;
			eof_s1       <= end_of_file;
		end
	end

	tlnds_encode u_encode (
		.data_byte   (data_byte_s1),
		.end_of_file (eof_s1),
		.state       (state_q),
		.seq         (seq),
		.state_next  (state_next)
	);

	tlnds_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (move),
		.seq          (seq),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.out_byte     (out_byte),
		.last         (last),
		.status       (ser_status)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		ser_status.count <= CntW'(MaxBytes))
		else $error("output byte count out of range");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> ser_status.count == $past(seq.count))
		else $error("serializer count does not match encoded item");

	a_eof_reset: assert property (@(posedge clk) disable iff (!arst_n)
		move && eof_s1 |=> state_q == StateReset)
		else $error("line state not reset after end of file");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid)
		else $error("input stalled with nothing in flight");

endmodule

### bench/text_line_normalizer_dot_stuffer_top_test.sv
`timescale 1ns / 1ps

module text_line_normalizer_dot_stuffer_top_test;
	import tlnds_pkg::*;

	typedef struct packed {
		byte_t value;
		logic  closes_item;
	} coded_byte_t;

	class stuffed_stream_board;
		coded_byte_t expected[$];
		bit          cr_held;
		bit          at_line_head;
		int          faults;

		function new();
			cr_held = 1'b0;
			at_line_head = 1'b1;
			faults = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			faults++;
		endtask

		function void push_byte(byte_t b);
			coded_byte_t entry;
			entry.value = b;
			entry.closes_item = 1'b0;
			expected.push_back(entry);
		endfunction

		function void push_line_end();
			push_byte(ChCr);
			push_byte(ChLf);
			at_line_head = 1'b1;
		endfunction

		function void note_item(byte_t b, logic eof);
			int before_cnt;
			bit swallowed;
			before_cnt = expected.size();
			swallowed = 1'b0;
			if (eof) begin
				if (cr_held) begin
					cr_held = 1'b0;
					push_line_end();
				end
				if (!at_line_head)
					push_line_end();
				push_byte(ChDot);
				push_byte(ChCr);
				push_byte(ChLf);
				cr_held = 1'b0;
				at_line_head = 1'b1;
			end else begin
				if (cr_held) begin
					cr_held = 1'b0;
					push_line_end();
					if (b == ChLf)
						swallowed = 1'b1;
				end
				if (!swallowed) begin
					if (b == ChCr) begin
						cr_held = 1'b1;
					end else if (b == ChLf) begin
						push_line_end();
					end else begin
						if (at_line_head && b == ChDot)
							push_byte(ChDot);
						push_byte(b);
						at_line_head = 1'b0;
					end
				end
			end
			if (expected.size() > before_cnt)
				expected[expected.size() - 1].closes_item = 1'b1;
		endfunction

		task check_byte(byte_t b, logic flag);
			coded_byte_t want;
			if (expected.size() == 0) begin
				report($sformatf("unexpected byte %h last %b", b, flag));
			end else begin
				want = expected.pop_front();
				if (b !== want.value)
					report($sformatf("out_byte %h, want %h", b, want.value));
				if (flag !== want.closes_item)
					report($sformatf("last %b, want %b on byte %h", flag, want.closes_item,
						want.value));
			end
		endtask
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_stall;
	byte_t data_byte = 8'h00;
	logic  end_of_file = 1'b0;
	logic  result_valid;
	logic  result_stall = 1'b0;
	byte_t out_byte;
	logic  last;

	stuffed_stream_board board = new();
	int sent = 0;
	bit steady = 1'b0;

	text_line_normalizer_dot_stuffer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.data_byte(data_byte),
		.end_of_file(end_of_file),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_byte(out_byte),
		.last(last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		result_stall <= !steady && ($urandom_range(99) < 12);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_byte(out_byte, last);
	end

	task automatic send_item(input byte_t b, input logic eof);
		steady = (sent >= 150 && sent < 230);
		while (!steady && $urandom_range(99) < 12) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		data_byte <= b;
		end_of_file <= eof;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		board.note_item(b, eof);
		sent++;
	endtask

	function automatic byte_t pick_text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return ChCr;
		if (r < 24)
			return ChLf;
		if (r < 34)
			return ChDot;
		return byte_t'($urandom_range(255));
	endfunction

	initial begin
		int len;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty file, then dots, CR runs, line ends and byte extremes
		send_item(8'hA5, 1'b1);
		send_item(ChDot, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(ChDot, 1'b0);
		send_item(ChCr, 1'b0);
		send_item(ChCr, 1'b0);
		send_item(ChLf, 1'b0);
		send_item(ChDot, 1'b0);
		send_item(ChDot, 1'b0);
		send_item(ChLf, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(ChCr, 1'b0);
		send_item(8'h5A, 1'b1);
		send_item(8'h78, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(ChLf, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(ChCr, 1'b0);
		send_item(8'h62, 1'b0);
		send_item(ChCr, 1'b0);
		send_item(ChLf, 1'b0);
		send_item(ChCr, 1'b0);
		send_item(ChDot, 1'b0);
		send_item(ChDot, 1'b1);

		while (sent < 360) begin
			len = $urandom_range(25);
			repeat (len)
				send_item(pick_text_byte(), 1'b0);
			send_item(byte_t'($urandom_range(255)), 1'b1);
		end
		item_valid <= 1'b0;

		while (board.expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.expected.size() != 0)
			board.report($sformatf("%0d bytes never arrived", board.expected.size()));

		if (board.faults == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### files.f
design/tlnds_pkg.sv
design/tlnds_encode.sv
design/tlnds_serializer.sv
design/text_line_normalizer_dot_stuffer_top.sv
bench/text_line_normalizer_dot_stuffer_top_test.sv
